>>> sv/fdss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdss_pkg: shared types and constants for the seven-segment scan core
// Display modes, segment glyphs and constant-divide helpers for digit split.
// ----------------------------------------------------------------------------
package fdss_pkg;

  typedef logic [7:0] seg_t;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_FULL  = 2'd1,
    MODE_OFF   = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  localparam logic [13:0] COUNT_MAX  = 14'd9999;
  localparam seg_t        SEG_BLANK  = 8'hFF;

  // reciprocal multipliers, exact for counts up to 9999
  localparam logic [13:0] RECIP_1000 = 14'd8389;  // shift 23
  localparam logic [13:0] RECIP_100  = 14'd5243;  // shift 19
  localparam logic [13:0] RECIP_10   = 14'd6554;  // shift 16
  localparam logic [7:0]  RECIP_10_S = 8'd205;    // shift 11, inputs below 1024

  localparam seg_t FULL_F = 8'h8E;
  localparam seg_t FULL_U = 8'hC1;
  localparam seg_t FULL_L = 8'hC7;

  function automatic seg_t digit_glyph(input logic [3:0] d);
    seg_t g;
    case (d)
      4'd0:    g = 8'b11000000;
      4'd1:    g = 8'b11111001;
      4'd2:    g = 8'b10100100;
      4'd3:    g = 8'b10110000;
      4'd4:    g = 8'b10011001;
      4'd5:    g = 8'b10010010;
      4'd6:    g = 8'b10000010;
      4'd7:    g = 8'b11111000;
      4'd8:    g = 8'b10000000;
      4'd9:    g = 8'b10010000;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

  // x mod 10 for x below 1024
  function automatic logic [3:0] mod10(input logic [9:0] x);
    logic [17:0] p;
    logic [6:0]  t;
    logic [9:0]  r;
    p = 18'(x) * 18'(RECIP_10_S);
    t = p[17:11];
    r = x - ((10'(t) << 3) + (10'(t) << 1));
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/four_digit_seven_segment_scan_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan_core: four-panel seven-segment scan
// Turns a count and a mode into four panel results with active-low segments.
// ----------------------------------------------------------------------------
// Each accepted request yields four results on the output channel, panel one
// to panel four, with panel select 3, 2, 1, 0 and last_panel_o high on the
// fourth. Sustained request rate is set by the output register, which drives
// one panel per cycle while out_ready_i is high; the first panel appears once
// the request has passed the digit split register, then glyph logic into the
// output register. Requests are taken while earlier panels are still being
// delivered. Counts above 9999 show as 9999; leading zero panels are blank;
// mode 3 behaves as off.
module four_digit_seven_segment_scan_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          func_i,
  input  wire logic [13:0]         count_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               panel_lines_o,
  output fdss_pkg::seg_t           segment_pattern_o,
  output logic                     last_panel_o
);
  import fdss_pkg::*;

  // split stage
  logic        s1_valid_q;
  logic [1:0]  s1_func_q;
  logic [13:0] s1_n_q;
  logic [3:0]  s1_q1000_q;
  logic [6:0]  s1_q100_q;
  logic [9:0]  s1_q10_q;

  logic [13:0] n_sat;
  logic [27:0] p1000, p100, p10;

  // output stage
  logic        out_valid_q;
  logic [1:0]  cnt_q;
  seg_t        seg_q [4];
  seg_t        seg_d [4];

  logic out_free, s1_free, in_fire, s2_load;

  assign out_free = !out_valid_q || (out_ready_i && cnt_q == 2'd3);
  assign s1_free  = !s1_valid_q || out_free;
  assign s2_load  = s1_valid_q && out_free;
  assign in_ready_o = s1_free;
  assign in_fire  = in_valid_i && s1_free;

  assign n_sat = (count_value_i > COUNT_MAX) ? COUNT_MAX : count_value_i;
  assign p1000 = 28'(n_sat) * 28'(RECIP_1000);
  assign p100  = 28'(n_sat) * 28'(RECIP_100);
  assign p10   = 28'(n_sat) * 28'(RECIP_10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_func_q  <= func_i;
      s1_n_q     <= n_sat;
      s1_q1000_q <= p1000[26:23];
      s1_q100_q  <= p100[25:19];
      s1_q10_q   <= p10[25:16];
    end
  end

  // glyph stage
  logic [13:0] ones_r;
  logic [3:0]  d_hund, d_tens, d_ones;

  always_comb begin
    ones_r = s1_n_q - ((14'(s1_q10_q) << 3) + (14'(s1_q10_q) << 1));
    d_ones = ones_r[3:0];
    d_hund = mod10(10'(s1_q100_q));
    d_tens = mod10(s1_q10_q);
    case (s1_func_q)
      MODE_COUNT: begin
        seg_d[0] = (s1_n_q < 14'd1000) ? SEG_BLANK : digit_glyph(s1_q1000_q);
        seg_d[1] = (s1_n_q < 14'd100)  ? SEG_BLANK : digit_glyph(d_hund);
        seg_d[2] = (s1_n_q < 14'd10)   ? SEG_BLANK : digit_glyph(d_tens);
        seg_d[3] = digit_glyph(d_ones);
      end
      MODE_FULL: begin
        seg_d[0] = FULL_F;
        seg_d[1] = FULL_U;
        seg_d[2] = FULL_L;
        seg_d[3] = FULL_L;
      end
      default: begin
        seg_d[0] = SEG_BLANK;
        seg_d[1] = SEG_BLANK;
        seg_d[2] = SEG_BLANK;
        seg_d[3] = SEG_BLANK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
      cnt_q       <= 2'd0;
    end else if (out_ready_i) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      seg_q <= seg_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign panel_lines_o     = ~cnt_q;
  assign segment_pattern_o = seg_q[cnt_q];
  assign last_panel_o      = (cnt_q == 2'd3);

endmodule
`default_nettype wire

>>> bench/four_digit_seven_segment_scan_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan_core_test: scan core self-checking bench
// Sends display requests through the input channel, first from a directed
// table, then at random. Each request must produce four panel results in
// order, and each result is compared against the glyphs typed in the
// directed table or, for other rows, a digit-split model of the panel
// glyphs. Bursty requests and patterned output stalls load the handshake.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_scan_core_test;
  import fdss_pkg::*;

  localparam int RANDOM_REQUESTS = 160;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int DIRECTED_ROWS   = 20;

  typedef struct packed {
    mode_e       mode;
    logic [13:0] count;
    logic        typed;
    logic [31:0] glyphs;
  } display_row_t;

  typedef struct {
    logic [1:0] lines;
    seg_t       seg;
    logic       last;
  } panel_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = MODE_COUNT;
  logic [13:0] count_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  panel_lines_o;
  seg_t        segment_pattern_o;
  logic        last_panel_o;

  panel_result_t pending_panels[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  int            burst_left = 0;

  display_row_t directed_rows [DIRECTED_ROWS];

  four_digit_seven_segment_scan_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .count_value_i     (count_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .panel_lines_o     (panel_lines_o),
    .segment_pattern_o (segment_pattern_o),
    .last_panel_o      (last_panel_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic seg_t numeral_glyph(input int d);
    seg_t glyph_rom [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                             8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
    return glyph_rom[d];
  endfunction

  // panel one in the top byte
  function automatic logic [31:0] panel_glyphs(input mode_e mode, input logic [13:0] count);
    int   n;
    seg_t p1, p2, p3, p4;
    n = (count > COUNT_MAX) ? int'(COUNT_MAX) : int'(count);
    case (mode)
      MODE_COUNT: begin
        p1 = (n < 1000) ? SEG_BLANK : numeral_glyph((n / 1000) % 10);
        p2 = (n < 100) ? SEG_BLANK : numeral_glyph((n / 100) % 10);
        p3 = (n < 10) ? SEG_BLANK : numeral_glyph((n / 10) % 10);
        p4 = numeral_glyph(n % 10);
      end
      MODE_FULL: begin
        p1 = 8'h8E;
        p2 = 8'hC1;
        p3 = 8'hC7;
        p4 = 8'hC7;
      end
      default: begin
        p1 = SEG_BLANK;
        p2 = SEG_BLANK;
        p3 = SEG_BLANK;
        p4 = SEG_BLANK;
      end
    endcase
    return {p1, p2, p3, p4};
  endfunction

  task automatic send_display_request(input mode_e mode, input logic [13:0] count,
                                      input logic typed, input logic [31:0] typed_glyphs);
    logic [31:0]   glyphs;
    panel_result_t panel;
    int            gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    func_i        <= mode;
    count_value_i <= count;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    glyphs = typed ? typed_glyphs : panel_glyphs(mode, count);
    for (int k = 0; k < 4; k++) begin
      panel.lines = 2'(3 - k);
      panel.seg   = glyphs[31 - 8 * k -: 8];
      panel.last  = (k == 3);
      pending_panels.push_back(panel);
    end
  endtask

  // receiver stall pattern rotates through four styles, stepped by cycle_count
  always @(posedge clk_i) begin : result_check
    panel_result_t want;
    int            style;
    style = (cycle_count / 64) % 4;
    case (style)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 1);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((cycle_count % 5) != 0);
    endcase
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_panels.size() == 0) begin
        $error("unexpected panel result lines=%0d seg=%02h", panel_lines_o, segment_pattern_o);
        mismatches++;
      end else begin
        want = pending_panels.pop_front();
        if (panel_lines_o !== want.lines) begin
          $error("panel_lines expected %0d actual %0d", want.lines, panel_lines_o);
          mismatches++;
        end
        if (segment_pattern_o !== want.seg) begin
          $error("segment_pattern expected %02h actual %02h", want.seg, segment_pattern_o);
          mismatches++;
        end
        if (last_panel_o !== want.last) begin
          $error("last_panel expected %0d actual %0d", want.last, last_panel_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("four_digit_seven_segment_scan_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    mode_e       mode;
    logic [13:0] count;
    int          pick;
    directed_rows = '{
      '{MODE_COUNT, 14'd0,     1'b1, 32'hFFFFFFC0},
      '{MODE_COUNT, 14'd9,     1'b0, 32'h0},
      '{MODE_COUNT, 14'd10,    1'b0, 32'h0},
      '{MODE_COUNT, 14'd99,    1'b0, 32'h0},
      '{MODE_COUNT, 14'd100,   1'b0, 32'h0},
      '{MODE_COUNT, 14'd999,   1'b0, 32'h0},
      '{MODE_COUNT, 14'd1000,  1'b0, 32'h0},
      '{MODE_COUNT, 14'd1234,  1'b0, 32'h0},
      '{MODE_COUNT, 14'd5678,  1'b0, 32'h0},
      '{MODE_COUNT, 14'd9999,  1'b1, 32'h90909090},
      '{MODE_COUNT, 14'd10000, 1'b1, 32'h90909090},
      '{MODE_COUNT, 14'd16383, 1'b1, 32'h90909090},
      '{MODE_COUNT, 14'd8,     1'b1, 32'hFFFFFF80},
      '{MODE_FULL,  14'd0,     1'b1, 32'h8EC1C7C7},
      '{MODE_FULL,  14'd16383, 1'b1, 32'h8EC1C7C7},
      '{MODE_OFF,   14'd0,     1'b1, 32'hFFFFFFFF},
      '{MODE_OFF,   14'd4321,  1'b1, 32'hFFFFFFFF},
      '{MODE_RSVD,  14'd1234,  1'b1, 32'hFFFFFFFF},
      '{MODE_RSVD,  14'd16383, 1'b1, 32'hFFFFFFFF},
      '{MODE_COUNT, 14'd10101, 1'b0, 32'h0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_display_request(directed_rows[i].mode, directed_rows[i].count,
                           directed_rows[i].typed, directed_rows[i].glyphs);
    end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) mode = MODE_COUNT;
      else if (pick == 7) mode = MODE_FULL;
      else if (pick == 8) mode = MODE_OFF;
      else mode = MODE_RSVD;
      case ($urandom_range(0, 5))
        0:       count = 14'($urandom_range(0, 9));
        1:       count = 14'($urandom_range(10, 99));
        2:       count = 14'($urandom_range(100, 999));
        3:       count = 14'($urandom_range(1000, 9999));
        4:       count = 14'($urandom_range(9990, 10010));
        default: count = 14'($urandom_range(0, 16383));
      endcase
      send_display_request(mode, count, 1'b0, 32'h0);
    end
    in_valid_i <= 1'b0;
    while (pending_panels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("four_digit_seven_segment_scan_core_test: PASS");
    end else begin
      $display("four_digit_seven_segment_scan_core_test: FAIL");
    end
    $finish;
  end

endmodule
